[rtl/pps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared sizes, controller state encoding and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MAX_JOBS = 16;
   localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   localparam int ID_W     = 8;
   localparam int ARR_W    = 16;
   localparam int BURST_W  = 16;
   localparam int PRI_W    = 8;
   localparam int TIME_W   = 21;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CHECK,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } sched_state_type;

   typedef struct packed {
      logic load;
      logic start_pass;
      logic scan;
      logic jump;
      logic run;
      logic emit;
      logic clear_set;
   } sched_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic found;
      logic all_done;
      logic out_free;
   } sched_status_type;

endpackage

[rtl/pps_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler channels
// Valid/ready channels for job requests and job results.
// ----------------------------------------------------------------------------
interface pps_req_if;
   import pps_pkg::*;

   logic             valid;
   logic             ready;
   logic [ID_W-1:0]  job_id;
   logic [ARR_W-1:0] arrival_time;
   logic [BURST_W-1:0] burst_length;
   logic [PRI_W-1:0] job_priority;
   logic             last_job;

   modport source (
      output valid, job_id, arrival_time, burst_length, job_priority, last_job,
      input  ready
   );
   modport sink (
      input  valid, job_id, arrival_time, burst_length, job_priority, last_job,
      output ready
   );
endinterface

interface pps_rsp_if;
   import pps_pkg::*;

   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   result_id;
   logic [TIME_W-1:0] completion_time;
   logic [TIME_W-1:0] turnaround_time;
   logic [TIME_W-1:0] waiting_time;
   logic              last_result;

   modport source (
      output valid, result_id, completion_time, turnaround_time, waiting_time,
             last_result,
      input  ready
   );
   modport sink (
      input  valid, result_id, completion_time, turnaround_time, waiting_time,
             last_result,
      output ready
   );
endinterface

[rtl/pps_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler datapath
// Job table, scan comparator, simulated clock and the result register.
// ----------------------------------------------------------------------------
module pps_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  pps_pkg::sched_cmd_type      cmd,
   output pps_pkg::sched_status_type   status,
   input  logic [pps_pkg::ID_W-1:0]    job_id,
   input  logic [pps_pkg::ARR_W-1:0]   arrival_time,
   input  logic [pps_pkg::BURST_W-1:0] burst_length,
   input  logic [pps_pkg::PRI_W-1:0]   job_priority,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [pps_pkg::ID_W-1:0]    result_id,
   output logic [pps_pkg::TIME_W-1:0]  completion_time,
   output logic [pps_pkg::TIME_W-1:0]  turnaround_time,
   output logic [pps_pkg::TIME_W-1:0]  waiting_time,
   output logic                        last_result
);
   import pps_pkg::*;

   logic [ID_W-1:0]    job_ids_ff   [MAX_JOBS];
   logic [ARR_W-1:0]   arrivals_ff  [MAX_JOBS];
   logic [BURST_W-1:0] bursts_ff    [MAX_JOBS];
   logic [BURST_W-1:0] remaining_ff [MAX_JOBS];
   logic [PRI_W-1:0]   priorities_ff[MAX_JOBS];
   logic [TIME_W-1:0]  finish_ff    [MAX_JOBS];

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   finished_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               found_ff;
   logic               any_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [PRI_W-1:0]   best_pri_ff;
   logic [ARR_W-1:0]   best_arr_ff;
   logic [BURST_W-1:0] best_rem_ff;
   logic [ARR_W-1:0]   next_ff;
   logic               out_valid_ff;
   logic [ID_W-1:0]    out_id_ff;
   logic [TIME_W-1:0]  out_comp_ff;
   logic [TIME_W-1:0]  out_tat_ff;
   logic [TIME_W-1:0]  out_wait_ff;
   logic               out_last_ff;

   logic [IDX_W-1:0]   slot;
   logic               full;
   logic [ARR_W-1:0]   r_arr;
   logic [BURST_W-1:0] r_rem;
   logic [PRI_W-1:0]   r_pri;
   logic               r_ready;
   logic               better;
   logic               sooner;
   logic [TIME_W-1:0]  gap;
   logic [BURST_W-1:0] run_len;
   logic [BURST_W-1:0] rem_in;
   logic [TIME_W-1:0]  time_in;
   logic [TIME_W-1:0]  tat_in;
   logic               idx_last;

   always_comb begin
      slot     = count_ff[IDX_W-1:0];
      full     = (count_ff == CNT_W'(MAX_JOBS));
      r_arr    = arrivals_ff[idx_ff];
      r_rem    = remaining_ff[idx_ff];
      r_pri    = priorities_ff[idx_ff];
      r_ready  = (TIME_W'(r_arr) <= time_ff);
      better   = !found_ff || (r_pri < best_pri_ff) ||
                 ((r_pri == best_pri_ff) && (r_arr < best_arr_ff));
      sooner   = !any_ff || (r_arr < next_ff);
      gap      = TIME_W'(next_ff) - time_ff;
      run_len  = (any_ff && (gap < TIME_W'(best_rem_ff))) ? gap[BURST_W-1:0] : best_rem_ff;
      rem_in   = best_rem_ff - run_len;
      time_in  = time_ff + TIME_W'(run_len);
      tat_in   = finish_ff[idx_ff] - TIME_W'(r_arr);
      idx_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         job_ids_ff[slot]    <= job_id;
         arrivals_ff[slot]   <= arrival_time;
         bursts_ff[slot]     <= burst_length;
         remaining_ff[slot]  <= burst_length;
         priorities_ff[slot] <= job_priority;
         if (burst_length == '0) begin
            finish_ff[slot] <= TIME_W'(arrival_time);
         end
      end
      if (cmd.run) begin
         remaining_ff[best_idx_ff] <= rem_in;
         if (rem_in == '0) begin
            finish_ff[best_idx_ff] <= time_in;
         end
      end
      if (cmd.scan && (r_rem != '0)) begin
         if (r_ready) begin
            if (better) begin
               best_idx_ff <= idx_ff;
               best_pri_ff <= r_pri;
               best_arr_ff <= r_arr;
               best_rem_ff <= r_rem;
            end
         end else if (sooner) begin
            next_ff <= r_arr;
         end
      end
      if (cmd.emit) begin
         out_id_ff   <= job_ids_ff[idx_ff];
         out_comp_ff <= finish_ff[idx_ff];
         out_tat_ff  <= tat_in;
         out_wait_ff <= tat_in - TIME_W'(bursts_ff[idx_ff]);
         out_last_ff <= idx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         finished_ff  <= '0;
         time_ff      <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         any_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && !full) begin
            count_ff <= count_ff + CNT_W'(1);
            if (burst_length == '0) begin
               finished_ff <= finished_ff + CNT_W'(1);
            end
         end
         if (cmd.start_pass) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            any_ff   <= 1'b0;
         end else if (cmd.scan || cmd.emit) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.scan && (r_rem != '0)) begin
            if (r_ready) begin
               found_ff <= 1'b1;
            end else if (sooner) begin
               any_ff <= 1'b1;
            end
         end
         if (cmd.jump) begin
            time_ff <= TIME_W'(next_ff);
         end
         if (cmd.run) begin
            time_ff <= time_in;
            if (rem_in == '0) begin
               finished_ff <= finished_ff + CNT_W'(1);
            end
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.clear_set) begin
            count_ff    <= '0;
            finished_ff <= '0;
            time_ff     <= '0;
         end
      end
   end

   always_comb begin
      status.idx_last = idx_last;
      status.found    = found_ff;
      status.all_done = (finished_ff == count_ff);
      status.out_free = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign result_id       = out_id_ff;
   assign completion_time = out_comp_ff;
   assign turnaround_time = out_tat_ff;
   assign waiting_time    = out_wait_ff;
   assign last_result     = out_last_ff;

endmodule

[rtl/pps_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler controller
// Sequences loading, the scheduling passes and the result drain.
// ----------------------------------------------------------------------------
module pps_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last,
   output logic                      req_ready,
   input  pps_pkg::sched_status_type status,
   output pps_pkg::sched_cmd_type    cmd
);
   import pps_pkg::*;

   sched_state_type state_ff;
   sched_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.start_pass = 1'b1;
            state_in = status.all_done ? ST_EMIT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.idx_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.found) begin
               cmd.run  = 1'b1;
               state_in = ST_CHECK;
            end else begin
               cmd.jump       = 1'b1;
               cmd.start_pass = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.idx_last) begin
                  cmd.clear_set = 1'b1;
                  state_in      = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

[rtl/preemptive_priority_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Loads a set of jobs, simulates preemptive priority scheduling over unit
// ticks and reports completion, turnaround and waiting time per job.
// ----------------------------------------------------------------------------
// Job requests are taken one per cycle until a request with last_job set;
// requests beyond 16 jobs are dropped, though their last flag still starts the
// run. Requests are then held off while the schedule is worked out. Each
// scheduling event (a job runs until it finishes or until the next arrival,
// or the clock jumps over an idle gap) takes one pass that reads the job
// table slot by slot through its single read port, then a decision step,
// and after a run a recheck of completion before the next pass. Results
// then leave in load order, one per cycle when the sink is ready, and a new
// set may be loaded while the final result still waits in the output register.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req_if,
   pps_rsp_if.source rsp_if
);
   import pps_pkg::*;

   sched_cmd_type    cmd;
   sched_status_type status;

   pps_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_job),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pps_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .job_id          (req_if.job_id),
      .arrival_time    (req_if.arrival_time),
      .burst_length    (req_if.burst_length),
      .job_priority    (req_if.job_priority),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .result_id       (rsp_if.result_id),
      .completion_time (rsp_if.completion_time),
      .turnaround_time (rsp_if.turnaround_time),
      .waiting_time    (rsp_if.waiting_time),
      .last_result     (rsp_if.last_result)
   );

endmodule

[rtl/pps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module pps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pps_pkg::ID_W-1:0]    result_id,
   input logic [pps_pkg::TIME_W-1:0]  completion_time,
   input logic [pps_pkg::TIME_W-1:0]  turnaround_time,
   input logic [pps_pkg::TIME_W-1:0]  waiting_time,
   input logic                        last_result
);
   import pps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(result_id) && $stable(completion_time) &&
         $stable(turnaround_time) && $stable(waiting_time) && $stable(last_result))
      else $error("result changed while stalled");

   a_last_stops_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken after the last job of a set");

   a_time_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (waiting_time <= turnaround_time) &&
         (turnaround_time <= completion_time))
      else $error("result times out of order");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_last        (req_if.last_job),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .result_id       (rsp_if.result_id),
   .completion_time (rsp_if.completion_time),
   .turnaround_time (rsp_if.turnaround_time),
   .waiting_time    (rsp_if.waiting_time),
   .last_result     (rsp_if.last_result)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Loads job sets through the request channel and predicts, per set, the
// completion, turnaround and waiting time of every job by replaying the
// preemptive schedule event by event. Each result is compared field by field
// with the oldest prediction. Directed sets cover field extremes, preemption,
// ties and table overflow; random sets follow, with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;
   import pps_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRI_W-1:0]   prio;
   } job_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              last;
   } job_report_type;

   logic clock;
   logic reset;

   pps_req_if req_if ();
   pps_rsp_if rsp_if ();

   preemptive_priority_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   job_entry_type  job_slots [MAX_JOBS];
   int unsigned    slots_filled;
   job_report_type pending_reports [$];

   bit          steady_flow;
   int unsigned rsp_hold_cycles;
   int unsigned mismatch_count;
   int unsigned sets_started;
   int unsigned jobs_sent;
   int unsigned reports_checked;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Replays the loaded set event by event and queues one report per job.
   function automatic void schedule_loaded_jobs();
      int unsigned    now;
      int unsigned    finished;
      int unsigned    best;
      int unsigned    next_arrival;
      int unsigned    span;
      int unsigned    elapsed;
      int unsigned    slack;
      int unsigned    remaining [MAX_JOBS];
      int unsigned    done_at [MAX_JOBS];
      bit             found;
      bit             any_future;
      job_report_type report;
      now = 0;
      finished = 0;
      for (int i = 0; i < slots_filled; i++) begin
         remaining[i] = 32'(job_slots[i].burst);
         if (remaining[i] == 0) begin
            done_at[i] = 32'(job_slots[i].arrival);
            finished++;
         end
      end
      while (finished < slots_filled) begin
         found = 1'b0;
         any_future = 1'b0;
         best = 0;
         next_arrival = 0;
         for (int i = 0; i < slots_filled; i++) begin
            if (remaining[i] == 0) continue;
            if (32'(job_slots[i].arrival) <= now) begin
               if (!found || job_slots[i].prio < job_slots[best].prio ||
                   (job_slots[i].prio == job_slots[best].prio &&
                    job_slots[i].arrival < job_slots[best].arrival)) begin
                  best = i;
                  found = 1'b1;
               end
            end else if (!any_future || 32'(job_slots[i].arrival) < next_arrival) begin
               next_arrival = 32'(job_slots[i].arrival);
               any_future = 1'b1;
            end
         end
         if (!found) begin
            now = next_arrival;
         end else begin
            span = remaining[best];
            if (any_future && next_arrival - now < span) span = next_arrival - now;
            remaining[best] -= span;
            now += span;
            if (remaining[best] == 0) begin
               done_at[best] = now;
               finished++;
            end
         end
      end
      for (int i = 0; i < slots_filled; i++) begin
         elapsed = done_at[i] - 32'(job_slots[i].arrival);
         slack = elapsed - 32'(job_slots[i].burst);
         report.id = job_slots[i].id;
         report.completion = done_at[i][TIME_W-1:0];
         report.turnaround = elapsed[TIME_W-1:0];
         report.waiting = slack[TIME_W-1:0];
         report.last = (i == slots_filled - 1);
         pending_reports.push_back(report);
      end
      slots_filled = 0;
   endfunction

   // The request stays valid after acceptance; the next call or a drain decides.
   task automatic send_job(input job_entry_type job, input logic last);
      while (!steady_flow && $urandom_range(99) < 6) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.job_id       <= job.id;
      req_if.arrival_time <= job.arrival;
      req_if.burst_length <= job.burst;
      req_if.job_priority <= job.prio;
      req_if.last_job     <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      jobs_sent++;
      if (slots_filled < MAX_JOBS) begin
         job_slots[slots_filled] = job;
         slots_filled++;
      end
      if (last) begin
         sets_started++;
         schedule_loaded_jobs();
      end
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned expected,
                              input int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_if.ready <= steady_flow || ($urandom_range(99) >= 6);
      end
   end

   always @(posedge clock) begin
      job_report_type expected;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_reports.size() == 0) begin
            $error("result for job %0d arrived with nothing expected", rsp_if.result_id);
            mismatch_count++;
         end else begin
            expected = pending_reports.pop_front();
            reports_checked++;
            check_field("result_id", 32'(expected.id), 32'(rsp_if.result_id));
            check_field("completion_time", 32'(expected.completion),
                        32'(rsp_if.completion_time));
            check_field("turnaround_time", 32'(expected.turnaround),
                        32'(rsp_if.turnaround_time));
            check_field("waiting_time", 32'(expected.waiting), 32'(rsp_if.waiting_time));
            check_field("last_result", 32'(expected.last), 32'(rsp_if.last_result));
         end
      end
   end

   function automatic job_entry_type random_job(input bit narrow_arrival,
                                                input bit narrow_burst,
                                                input bit narrow_prio);
      job_entry_type job;
      job.id      = ID_W'($urandom_range(255));
      job.arrival = ARR_W'(narrow_arrival ? $urandom_range(40) : $urandom_range(65535));
      job.burst   = BURST_W'(narrow_burst ? $urandom_range(1, 16)
                                          : $urandom_range(1, 65535));
      job.prio    = PRI_W'(narrow_prio ? $urandom_range(3) : $urandom_range(255));
      return job;
   endfunction

   task automatic test_extreme_single_jobs();
      send_job('{id: 8'hFF, arrival: 16'hFFFF, burst: 16'hFFFF, prio: 8'hFF}, 1'b1);
      send_job('{id: 8'h00, arrival: 16'h0000, burst: 16'h0001, prio: 8'h00}, 1'b1);
   endtask

   // A low-priority job is preempted once, two jobs tie on priority and
   // arrival, and an idle gap precedes the final job.
   task automatic test_preemption_and_ties();
      send_job('{id: 8'd10, arrival: 16'd0,  burst: 16'd10, prio: 8'd5}, 1'b0);
      send_job('{id: 8'd11, arrival: 16'd1,  burst: 16'd1,  prio: 8'd5}, 1'b0);
      send_job('{id: 8'd12, arrival: 16'd3,  burst: 16'd4,  prio: 8'd1}, 1'b0);
      send_job('{id: 8'd13, arrival: 16'd3,  burst: 16'd2,  prio: 8'd1}, 1'b0);
      send_job('{id: 8'd14, arrival: 16'd30, burst: 16'd2,  prio: 8'd0}, 1'b1);
   endtask

   // Seventeen requests: the last one is dropped but still starts the run.
   task automatic test_table_overflow();
      for (int i = 0; i <= MAX_JOBS; i++) begin
         send_job(random_job(1'b1, 1'b1, 1'b1), i == MAX_JOBS);
      end
   endtask

   task automatic test_random_sets();
      int unsigned random_jobs;
      int unsigned set_size;
      bit          narrow_arrival;
      bit          narrow_burst;
      bit          narrow_prio;
      random_jobs = 0;
      while (random_jobs < 75) begin
         set_size = ($urandom_range(7) == 0) ? $urandom_range(MAX_JOBS + 1, MAX_JOBS + 3)
                                             : $urandom_range(1, MAX_JOBS);
         narrow_arrival = $urandom_range(2) != 0;
         narrow_burst   = $urandom_range(2) != 0;
         narrow_prio    = $urandom_range(1) != 0;
         steady_flow    = ($urandom_range(3) == 0);
         for (int i = 0; i < set_size; i++) begin
            send_job(random_job(narrow_arrival, narrow_burst && $urandom_range(7) != 0,
                                narrow_prio), i == set_size - 1);
         end
         random_jobs += set_size;
      end
      steady_flow = 1'b0;
   endtask

   // The result side stalls for a long stretch while several sets are offered,
   // so the block holds results and stops taking requests.
   task automatic test_output_backpressure();
      steady_flow = 1'b1;
      rsp_hold_cycles = 400;
      for (int s = 0; s < 3; s++) begin
         for (int i = 0; i < 4; i++) begin
            send_job(random_job(1'b1, 1'b1, 1'b1), i == 3);
         end
      end
      steady_flow = 1'b0;
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      steady_flow = 1'b0;
      rsp_hold_cycles = 0;
      mismatch_count = 0;
      sets_started = 0;
      jobs_sent = 0;
      reports_checked = 0;
      slots_filled = 0;
      req_if.valid = 1'b0;
      req_if.job_id = '0;
      req_if.arrival_time = '0;
      req_if.burst_length = '0;
      req_if.job_priority = '0;
      req_if.last_job = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_single_jobs();
      test_preemption_and_ties();
      test_table_overflow();
      test_random_sets();
      test_output_backpressure();
      drain_results();
      repeat (40) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d job results never arrived", pending_reports.size());
         mismatch_count++;
      end
      $display("Ran %0d job sets from %0d requests, including overflow and stalls.",
               sets_started, jobs_sent);
      $display("Checked %0d job results, %0d field errors.", reports_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
